/* rtl/gspc_pkg.sv */
// Shared types and constants for the gas sensor ppm converter.
// Holds register index codes, status codes and the exp2 root table.
// No dependencies.
`timescale 1ns / 1ps

package gspc_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_LOAD_RES        = 3'd0,
        CFG_CLEAN_AIR_RES   = 3'd1,
        CFG_CLEAN_AIR_RATIO = 3'd2,
        CFG_CURVE_SCALE     = 3'd3,
        CFG_CURVE_EXP       = 3'd4,
        CFG_SUPPLY          = 3'd5
    } cfg_reg_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_ZERO_SAMPLE = 2'd1,
        STATUS_PPM_SAT     = 2'd2
    } status_t;

    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

    // Register reset values
    localparam logic [31:0] LOAD_RES_RST      = 32'd655360;
    localparam logic [31:0] CLEAN_AIR_RES_RST = 32'd1289290;
    localparam logic [31:0] CLEAN_AIR_RAT_RST = 32'd425984;
    localparam logic [31:0] CURVE_SCALE_RST   = 32'd20710;
    localparam logic [15:0] CURVE_EXP_RST     = 16'hD91B;
    localparam logic [15:0] SUPPLY_RST        = 16'd1280;

    // 5 V full scale in Q8.8
    localparam logic [10:0] FULL_SCALE_Q8 = 11'd1280;

    // Quotient bits kept by the resistance divider (enough to see saturation)
    localparam int RS_Q_BITS = 34;

    // Fraction bits of log2 and exp2
    localparam int LOG_FRAC_BITS = 16;

    // 1.0 in Q1.31
    localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

    typedef logic [LOG_FRAC_BITS:0][31:0] root_tab_t;

    // Integer square root of a 64-bit value, bit by bit
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] rem;
        logic [63:0] bt;
        r   = '0;
        rem = v;
        bt  = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (rem >= r + bt) begin
                rem = rem - (r + bt);
                r   = (r >> 1) + bt;
            end else begin
                r = r >> 1;
            end
            bt = bt >> 2;
        end
        return r;
    endfunction

    // Q1.31 values of 2^(2^-k): each entry is the square root of the one before
    function automatic root_tab_t calc_roots();
        root_tab_t   t;
        logic [63:0] prev;
        t    = '0;
        prev = 64'h1_0000_0000;
        for (int k = 1; k <= LOG_FRAC_BITS; k++) begin
            prev = isqrt64(prev << 31);
            t[k] = prev[31:0];
        end
        return t;
    endfunction

    localparam root_tab_t ROOT_TAB = calc_roots();

endpackage

/* rtl/gas_sensor_ppm_converter.sv */
// Gas sensor ppm converter top level: ADC sample in, Rs, baseline and ppm out.
// Depends on gspc_pkg and gspc_log2.
`timescale 1ns / 1ps

// One sample enters per cycle except while a held result stalls the output;
// the block sustains one beat per clock under that same condition. The depth
// comes from the Rs divider (2 quotient bits per stage, 17 stages), the log2
// unit and baseline divider running side by side (18 stages), and the exp2
// chain (one Q1.31 multiply per fraction bit, 16 stages). A stalled output
// freezes the whole pipeline, so the input stalls only while a finished result
// waits. Configuration is to be taken only while the block is idle; the block
// does not enforce this. The clean-air log2 is recomputed continuously.

module gas_sensor_ppm_converter #(
    parameter int ADC_BITS = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [gspc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [31:0]                          cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [ADC_BITS-1:0]                  adc_sample,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [31:0]                          sensor_resistance,
    output logic [31:0]                          baseline_estimate,
    output logic [31:0]                          concentration,
    output logic [1:0]                           status
);

    localparam int QB         = gspc_pkg::RS_Q_BITS;
    localparam int W_N        = 48 + ADC_BITS;
    localparam int W_NH       = W_N - QB;
    localparam int W_D        = ADC_BITS + 11;
    localparam int DIV_STAGES = QB / 2;
    localparam int BASE_STEPS = 16;
    localparam int BASE_LAST  = BASE_STEPS + 1;
    localparam int FB         = gspc_pkg::LOG_FRAC_BITS;
    localparam int E_LAST     = FB + 4;

    // ------------------------------------------------------------------
    // Configuration registers
    logic [31:0] load_reg;
    logic [31:0] clean_res_reg;
    logic [31:0] ratio_reg;
    logic [31:0] scale_reg;
    logic [15:0] expo_reg;
    logic [15:0] supply_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg      <= gspc_pkg::LOAD_RES_RST;
            clean_res_reg <= gspc_pkg::CLEAN_AIR_RES_RST;
            ratio_reg     <= gspc_pkg::CLEAN_AIR_RAT_RST;
            scale_reg     <= gspc_pkg::CURVE_SCALE_RST;
            expo_reg      <= gspc_pkg::CURVE_EXP_RST;
            supply_reg    <= gspc_pkg::SUPPLY_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                gspc_pkg::CFG_LOAD_RES:        load_reg      <= cfg_data;
                gspc_pkg::CFG_CLEAN_AIR_RES:   clean_res_reg <= cfg_data;
                gspc_pkg::CFG_CLEAN_AIR_RATIO: ratio_reg     <= cfg_data;
                gspc_pkg::CFG_CURVE_SCALE:     scale_reg     <= cfg_data;
                gspc_pkg::CFG_CURVE_EXP:       expo_reg      <= cfg_data[15:0];
                gspc_pkg::CFG_SUPPLY:          supply_reg    <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Dividend supply * RL * full_scale, refreshed from the registers
    logic [47:0]    nprod_reg;
    logic [W_N-1:0] n_reg;

    always_ff @(posedge clk)
    begin
        nprod_reg <= 48'(supply_reg) * 48'(load_reg);
        n_reg     <= {nprod_reg, ADC_BITS'(0)} - {ADC_BITS'(0), nprod_reg};
    end

    // Clean-air log2, zero treated as the smallest resistance
    logic [31:0] r0_val;
    logic [20:0] lr0;

    assign r0_val = (clean_res_reg == '0) ? 32'd1 : clean_res_reg;

    gspc_log2 u_log2_r0 (
        .clk (clk),
        .en  (1'b1),
        .x   (r0_val),
        .y   (lr0)
    );

    // ------------------------------------------------------------------
    // Pipeline advance: freeze only while a finished result is held
    logic adv;
    logic out_valid_reg;

    assign adv      = ~(out_valid_reg & out_stall);
    assign in_stall = ~adv;

    // Valid bits for every stage
    logic           a_v_reg;
    logic           b_v_reg;
    logic           dv_reg [DIV_STAGES+1];
    logic           rs_v_reg;
    logic           bv_reg [BASE_LAST+1];
    logic           ev_reg [1:E_LAST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg  <= 1'b0;
            b_v_reg  <= 1'b0;
            rs_v_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j <= DIV_STAGES; j++)
            begin
                dv_reg[j] <= 1'b0;
            end
            for (int j = 0; j <= BASE_LAST; j++)
            begin
                bv_reg[j] <= 1'b0;
            end
            for (int j = 1; j <= E_LAST; j++)
            begin
                ev_reg[j] <= 1'b0;
            end
        end
        else if (adv)
        begin
            a_v_reg   <= in_valid;
            b_v_reg   <= a_v_reg;
            dv_reg[0] <= b_v_reg;
            for (int j = 1; j <= DIV_STAGES; j++)
            begin
                dv_reg[j] <= dv_reg[j-1];
            end
            rs_v_reg  <= dv_reg[DIV_STAGES];
            bv_reg[0] <= rs_v_reg;
            for (int j = 1; j <= BASE_LAST; j++)
            begin
                bv_reg[j] <= bv_reg[j-1];
            end
            ev_reg[1] <= bv_reg[BASE_LAST];
            for (int j = 2; j <= E_LAST; j++)
            begin
                ev_reg[j] <= ev_reg[j-1];
            end
            out_valid_reg <= ev_reg[E_LAST];
        end
    end

    // ------------------------------------------------------------------
    // Capture the sample, then form the divisor 1280 * sample
    logic [ADC_BITS-1:0] a_s_reg;
    logic                b_z_reg;
    logic [W_D-1:0]      b_d_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_s_reg <= adc_sample;
            b_z_reg <= (a_s_reg == '0);
            b_d_reg <= W_D'(a_s_reg) * W_D'(gspc_pkg::FULL_SCALE_Q8);
        end
    end

    // ------------------------------------------------------------------
    // Rs divider: overflow check, then two quotient bits per stage
    logic           dz_reg [DIV_STAGES+1];
    logic [W_D-1:0] dd_reg [DIV_STAGES+1];
    logic [W_D-1:0] dr_reg [DIV_STAGES+1];
    logic [QB-1:0]  dq_reg [DIV_STAGES+1];
    logic           dov_reg[DIV_STAGES+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dz_reg[0]  <= b_z_reg;
            dd_reg[0]  <= b_d_reg;
            dr_reg[0]  <= n_reg[QB +: W_D];
            dq_reg[0]  <= '0;
            dov_reg[0] <= (n_reg[W_N-1:QB] >= W_NH'(b_d_reg));
        end
    end

    for (genvar j = 1; j <= DIV_STAGES; j++)
    begin : g_rs_div
        localparam int HI = QB + 1 - 2 * j;
        logic [W_D:0]   t1;
        logic [W_D:0]   t2;
        logic           ge1;
        logic           ge2;
        logic [W_D-1:0] r1;
        logic [W_D-1:0] rem_next;
        logic [QB-1:0]  quo_next;

        always_comb
        begin
            t1  = {dr_reg[j-1], n_reg[HI]};
            ge1 = (t1 >= {1'b0, dd_reg[j-1]});
            r1  = ge1 ? W_D'(t1 - {1'b0, dd_reg[j-1]}) : t1[W_D-1:0];
            t2  = {r1, n_reg[HI-1]};
            ge2 = (t2 >= {1'b0, dd_reg[j-1]});
            rem_next = ge2 ? W_D'(t2 - {1'b0, dd_reg[j-1]}) : t2[W_D-1:0];
            quo_next = dq_reg[j-1];
            quo_next[HI]   = ge1;
            quo_next[HI-1] = ge2;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dz_reg[j]  <= dz_reg[j-1];
                dd_reg[j]  <= dd_reg[j-1];
                dr_reg[j]  <= rem_next;
                dq_reg[j]  <= quo_next;
                dov_reg[j] <= dov_reg[j-1];
            end
        end
    end

    // Subtract RL, clamp at zero, saturate
    logic          rs_z_reg;
    logic [31:0]   rs_reg;
    logic [31:0]   rs_next;
    logic [QB-1:0] rs_diff;

    always_comb
    begin
        rs_diff = dq_reg[DIV_STAGES] - QB'(load_reg);
        if (dz_reg[DIV_STAGES] || dov_reg[DIV_STAGES])
        begin
            rs_next = gspc_pkg::MAX32;
        end
        else if (dq_reg[DIV_STAGES] <= QB'(load_reg))
        begin
            rs_next = '0;
        end
        else if (rs_diff[QB-1:32] != '0)
        begin
            rs_next = gspc_pkg::MAX32;
        end
        else
        begin
            rs_next = rs_diff[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rs_z_reg <= dz_reg[DIV_STAGES];
            rs_reg   <= rs_next;
        end
    end

    // ------------------------------------------------------------------
    // log2(Rs), aligned with the baseline divider
    logic [20:0] lrs;

    gspc_log2 u_log2_rs (
        .clk (clk),
        .en  (adv),
        .x   (rs_reg),
        .y   (lrs)
    );

    // Baseline divider: (Rs << 16) / ratio, two bits per stage
    logic        bz_reg  [BASE_LAST+1];
    logic [31:0] brs_reg [BASE_LAST+1];
    logic [31:0] brem_reg[BASE_STEPS+1];
    logic [31:0] bq_reg  [BASE_STEPS+1];
    logic        bov_reg [BASE_STEPS+1];
    logic [31:0] bbase_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bz_reg[0]   <= rs_z_reg;
            brs_reg[0]  <= rs_reg;
            brem_reg[0] <= {16'h0, rs_reg[31:16]};
            bq_reg[0]   <= '0;
            bov_reg[0]  <= (ratio_reg == '0) || ({16'h0, rs_reg[31:16]} >= ratio_reg);
        end
    end

    for (genvar j = 1; j <= BASE_STEPS; j++)
    begin : g_base_div
        localparam int HI = 33 - 2 * j;
        logic [31:0] xlo;
        logic [32:0] t1;
        logic [32:0] t2;
        logic        ge1;
        logic        ge2;
        logic [31:0] r1;
        logic [31:0] rem_next;
        logic [31:0] quo_next;

        always_comb
        begin
            xlo = {brs_reg[j-1][15:0], 16'h0};
            t1  = {brem_reg[j-1], xlo[HI]};
            ge1 = (t1 >= {1'b0, ratio_reg});
            r1  = ge1 ? 32'(t1 - {1'b0, ratio_reg}) : t1[31:0];
            t2  = {r1, xlo[HI-1]};
            ge2 = (t2 >= {1'b0, ratio_reg});
            rem_next = ge2 ? 32'(t2 - {1'b0, ratio_reg}) : t2[31:0];
            quo_next = bq_reg[j-1];
            quo_next[HI]   = ge1;
            quo_next[HI-1] = ge2;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                bz_reg[j]   <= bz_reg[j-1];
                brs_reg[j]  <= brs_reg[j-1];
                brem_reg[j] <= rem_next;
                bq_reg[j]   <= quo_next;
                bov_reg[j]  <= bov_reg[j-1];
            end
        end
    end

    // Saturate the baseline
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bz_reg[BASE_LAST]  <= bz_reg[BASE_STEPS];
            brs_reg[BASE_LAST] <= brs_reg[BASE_STEPS];
            bbase_reg <= bov_reg[BASE_STEPS] ? gspc_pkg::MAX32 : bq_reg[BASE_STEPS];
        end
    end

    // ------------------------------------------------------------------
    // Power law: d = log2 Rs - log2 R0, e = b * d, ppm = a * 2^e
    logic               ez_reg   [1:E_LAST];
    logic [31:0]        ers_reg  [1:E_LAST];
    logic [31:0]        ebase_reg[1:E_LAST];
    logic signed [21:0] dl_reg;
    logic signed [9:0]  ip_reg   [2:FB+3];
    logic [FB-1:0]      fp_reg   [2:FB+2];
    logic [31:0]        xm_reg   [3:FB+2];
    logic [63:0]        pp_reg;
    logic [31:0]        ppm_reg;
    logic               sat_reg;
    logic signed [21:0] dl_next;
    logic signed [37:0] be_next;

    assign dl_next = $signed({1'b0, lrs}) - $signed({1'b0, lr0});
    assign be_next = 38'($signed(expo_reg)) * 38'(dl_reg);

    // Enter the power law, then scale the log difference by b
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ez_reg[1]    <= bz_reg[BASE_LAST];
            ers_reg[1]   <= brs_reg[BASE_LAST];
            ebase_reg[1] <= bbase_reg;
            dl_reg       <= dl_next;
            ip_reg[2]    <= be_next[37:28];
            fp_reg[2]    <= be_next[27:12];
        end
    end

    // Carry the side results along the power-law stages
    for (genvar e = 2; e <= E_LAST; e++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ez_reg[e]    <= ez_reg[e-1];
                ers_reg[e]   <= ers_reg[e-1];
                ebase_reg[e] <= ebase_reg[e-1];
            end
        end
    end

    // exp2 of the fraction: one root multiply per fraction bit
    for (genvar k = 1; k <= FB; k++)
    begin : g_exp
        logic [31:0] prev;
        logic [63:0] prod;
        logic [31:0] xm_next;

        if (k == 1)
        begin : g_first
            assign prev = gspc_pkg::ONE_Q31;
        end
        else
        begin : g_rest
            assign prev = xm_reg[k+1];
        end

        always_comb
        begin
            prod    = 64'(prev) * 64'(gspc_pkg::ROOT_TAB[k]);
            xm_next = fp_reg[k+1][FB-k] ? prod[62:31] : prev;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                xm_reg[k+2] <= xm_next;
                ip_reg[k+2] <= ip_reg[k+1];
                fp_reg[k+2] <= fp_reg[k+1];
            end
        end
    end

    // Scale by a
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pp_reg      <= 64'(scale_reg) * 64'(xm_reg[FB+2]);
            ip_reg[FB+3] <= ip_reg[FB+2];
        end
    end

    // Apply the integer exponent as a shift, saturate
    logic [32:0] q33;
    logic [64:0] shl;
    logic [10:0] nsh;
    logic [63:0] shr;
    logic [31:0] ppm_next;
    logic        sat_next;

    always_comb
    begin
        q33      = pp_reg[63:31];
        shl      = {32'h0, q33} << ip_reg[FB+3][5:0];
        nsh      = 11'd31 - {ip_reg[FB+3][9], ip_reg[FB+3]};
        shr      = pp_reg >> nsh[5:0];
        ppm_next = '0;
        sat_next = 1'b0;
        if (!ip_reg[FB+3][9])
        begin
            if (q33 == '0)
            begin
                ppm_next = '0;
            end
            else if (ip_reg[FB+3][8:0] >= 9'd33 || shl[64:32] != '0)
            begin
                ppm_next = gspc_pkg::MAX32;
                sat_next = 1'b1;
            end
            else
            begin
                ppm_next = shl[31:0];
            end
        end
        else if (nsh >= 11'd64)
        begin
            ppm_next = '0;
        end
        else
        begin
            ppm_next = shr[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ppm_reg <= ppm_next;
            sat_reg <= sat_next;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: zero Rs handling and status
    logic [31:0]       sres_reg;
    logic [31:0]       base_out_reg;
    logic [31:0]       conc_reg;
    gspc_pkg::status_t status_reg;
    logic [31:0]       conc_next;
    logic              osat_next;
    gspc_pkg::status_t status_next;

    always_comb
    begin
        conc_next = ppm_reg;
        osat_next = sat_reg;
        if (ers_reg[E_LAST] == '0)
        begin
            if (expo_reg[15])
            begin
                conc_next = gspc_pkg::MAX32;
                osat_next = 1'b1;
            end
            else if (expo_reg == '0)
            begin
                conc_next = scale_reg;
                osat_next = 1'b0;
            end
            else
            begin
                conc_next = '0;
                osat_next = 1'b0;
            end
        end
        if (ez_reg[E_LAST])
        begin
            status_next = gspc_pkg::STATUS_ZERO_SAMPLE;
        end
        else if (osat_next)
        begin
            status_next = gspc_pkg::STATUS_PPM_SAT;
        end
        else
        begin
            status_next = gspc_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sres_reg     <= ers_reg[E_LAST];
            base_out_reg <= ebase_reg[E_LAST];
            conc_reg     <= conc_next;
            status_reg   <= status_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign sensor_resistance = sres_reg;
    assign baseline_estimate = base_out_reg;
    assign concentration     = conc_reg;
    assign status            = status_reg;

endmodule

/* rtl/gspc_log2.sv */
// Pipelined log2 of a 32-bit unsigned value, result in Q5.16.
// Uses gspc_pkg for the fraction width.
`timescale 1ns / 1ps

module gspc_log2 (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] x,
    output logic [20:0] y
);

    localparam int STEPS = gspc_pkg::LOG_FRAC_BITS;

    logic [31:0]      x0_reg;
    logic [4:0]       p0_reg;
    logic [4:0]       lead_next;
    logic [31:0]      m_reg  [STEPS+1];
    logic [4:0]       p_reg  [STEPS+1];
    logic [STEPS-1:0] fr_reg [STEPS+1];

    // Find the top set bit
    always_comb
    begin
        lead_next = '0;
        for (int i = 1; i < 32; i++)
        begin
            if (x[i])
            begin
                lead_next = 5'(i);
            end
        end
    end

    // Capture operand and leading bit index
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg <= x;
            p0_reg <= lead_next;
        end
    end

    // Normalize to a Q1.31 mantissa
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0]  <= x0_reg << (5'd31 - p0_reg);
            p_reg[0]  <= p0_reg;
            fr_reg[0] <= '0;
        end
    end

    // One fraction bit per stage by squaring the mantissa
    for (genvar i = 1; i <= STEPS; i++)
    begin : g_sq
        logic [63:0]      sq;
        logic [32:0]      t;
        logic [31:0]      m_next;
        logic [STEPS-1:0] fr_next;

        always_comb
        begin
            sq      = 64'(m_reg[i-1]) * 64'(m_reg[i-1]);
            t       = sq[63:31];
            fr_next = fr_reg[i-1];
            fr_next[STEPS-i] = t[32];
            m_next  = t[32] ? t[32:1] : t[31:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg[i]  <= m_next;
                p_reg[i]  <= p_reg[i-1];
                fr_reg[i] <= fr_next;
            end
        end
    end

    assign y = {p_reg[STEPS], fr_reg[STEPS]};

endmodule

/* rtl/gspc_checker.sv */
// Port-level checks for the gas sensor ppm converter, bound to the top level.
// Depends on gspc_pkg for status codes and the saturation value.
`timescale 1ns / 1ps

module gspc_port_checks (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] sensor_resistance,
    input logic [31:0] concentration,
    input logic [1:0]  status
);

    // Zero sample reports a saturated resistance
    a_zero_sample_rs: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == gspc_pkg::STATUS_ZERO_SAMPLE
        |-> sensor_resistance == gspc_pkg::MAX32)
        else $error("zero-sample beat without saturated resistance");

    // Saturated ppm status carries the saturated value
    a_ppm_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == gspc_pkg::STATUS_PPM_SAT
        |-> concentration == gspc_pkg::MAX32)
        else $error("ppm saturation status without saturated concentration");

    // Input stalls only behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with no held result");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall
        |=> out_valid && $stable(concentration) && $stable(status))
        else $error("stalled result beat changed");

endmodule

bind gas_sensor_ppm_converter gspc_port_checks u_gspc_port_checks (.*);
